/* hw/rtl/btpc_pkg.sv */
// Shared types, register codes and helper functions for the compensation block.
package btpc_pkg;

  localparam int unsigned AddrWidth = 6;
  localparam int unsigned DivSteps  = 32;

  localparam logic [2:0] REG_T1 = 3'd0;
  localparam logic [2:0] REG_T2 = 3'd1;
  localparam logic [2:0] REG_T3 = 3'd2;
  localparam logic [2:0] REG_P1 = 3'd3;
  localparam logic [2:0] REG_PLO = 3'd4;
  localparam logic [2:0] REG_PHI = 3'd5;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [63:0] plo;
    logic [63:0] phi;
  } cfg_t;

  // front end result handed to the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] divisor;
    logic [31:0] num;
  } front_t;

  // fields that ride along with the division
  typedef struct packed {
    logic [31:0] temp;
    logic        big;
    logic        zero;
  } side_t;

  typedef struct packed {
    logic [31:0] quo;
    side_t       side;
  } quo_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

/* hw/rtl/btpc_in_if.sv */
// Input channel: one raw temperature and pressure reading pair.
interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] temp_adc;
  logic [19:0] press_adc;

  modport source (output valid, temp_adc, press_adc, input ready);
  modport sink (input valid, temp_adc, press_adc, output ready);
endinterface

/* hw/rtl/btpc_out_if.sv */
// Output channel: compensated temperature and pressure.
interface btpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temperature_centi;
  logic [31:0] pressure_pascal;
  logic        divisor_zero;

  modport source (output valid, temperature_centi, pressure_pascal, divisor_zero,
                  input ready);
  modport sink (input valid, temperature_centi, pressure_pascal, divisor_zero,
                output ready);
endinterface

/* hw/rtl/baro_temp_pressure_compensation.sv */
// Top level of the barometric temperature and pressure compensation pipeline.
// Usage:
//   sample_i (sink) takes one raw 20-bit temperature and pressure pair per transfer.
//   result_o (source) gives the temperature in 0.01 degC, the pressure in Pa and
//   a flag that is set when the pressure divisor was zero (pressure is then 0).
//   Calibration coefficients must be written over the APB-style port only while
//   the pipeline is empty; the block does not enforce this. Register i sits at
//   byte address 8*i.
// Pipeline: 11 front-end stages, 32 divider stages (one quotient bit each) and
//   4 correction stages, the last being the output register.
// Throughput: one reading pair per cycle unless a stall holds the pipeline.
// Reset clears all valid bits and all coefficients to zero.
// Stall: when a result waits and result_o.ready is low, the whole pipeline
//   holds and sample_i.ready drops; nothing is lost or repeated.
module baro_temp_pressure_compensation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  btpc_in_if.sink                        sample_i,
  btpc_out_if.source                     result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btpc_pkg::AddrWidth-1:0] paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready
);
  import btpc_pkg::*;

  cfg_t   cfg;
  front_t front;
  quo_t   quo;
  logic   en, front_v, div_v, out_v;

  // advance everything unless a finished result is still waiting
  assign en             = !out_v || result_o.ready;
  assign sample_i.ready = en;
  assign result_o.valid = out_v;

  btpc_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  btpc_front u_front (
    .clk_i, .rst_ni,
    .en_i        (en),
    .cfg_i       (cfg),
    .valid_i     (sample_i.valid),
    .temp_adc_i  (sample_i.temp_adc),
    .press_adc_i (sample_i.press_adc),
    .valid_o     (front_v),
    .data_o      (front)
  );

  btpc_div u_div (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (front_v),
    .data_i  (front),
    .valid_o (div_v),
    .data_o  (quo)
  );

  btpc_post u_post (
    .clk_i, .rst_ni,
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (div_v),
    .data_i  (quo),
    .valid_o (out_v),
    .temp_o  (result_o.temperature_centi),
    .press_o (result_o.pressure_pascal),
    .zero_o  (result_o.divisor_zero)
  );
endmodule

/* hw/rtl/btpc_cfg.sv */
// Calibration coefficient registers behind the APB-style port.
module btpc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btpc_pkg::AddrWidth-1:0] paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready,
  output btpc_pkg::cfg_t                 cfg_o
);
  import btpc_pkg::*;

  cfg_t        cfg_q;
  logic        wr;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_T1:  cfg_q.t1  <= pwdata[15:0];
        REG_T2:  cfg_q.t2  <= pwdata[15:0];
        REG_T3:  cfg_q.t3  <= pwdata[15:0];
        REG_P1:  cfg_q.p1  <= pwdata[15:0];
        REG_PLO: cfg_q.plo <= pwdata;
        REG_PHI: cfg_q.phi <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_T1:  prdata = {48'd0, cfg_q.t1};
      REG_T2:  prdata = {48'd0, cfg_q.t2};
      REG_T3:  prdata = {48'd0, cfg_q.t3};
      REG_P1:  prdata = {48'd0, cfg_q.p1};
      REG_PLO: prdata = cfg_q.plo;
      REG_PHI: prdata = cfg_q.phi;
      default: prdata = '0;
    endcase
  end
endmodule

/* hw/rtl/btpc_front.sv */
// Fine temperature, temperature output and pressure dividend/divisor pipeline.
module btpc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  btpc_pkg::cfg_t          cfg_i,
  input  logic                    valid_i,
  input  logic [19:0]             temp_adc_i,
  input  logic [19:0]             press_adc_i,
  output logic                    valid_o,
  output btpc_pkg::front_t        data_o
);
  import btpc_pkg::*;

  localparam int unsigned Stages = 11;

  logic [Stages-1:0] v_q;
  logic [19:0] rp_q [1:9];
  logic [31:0] temp_q [6:11];
  logic [31:0] a0_q, d_q, a1_q, dd_q, a3_q, b3_q, fine_q, t5_q, v15_q;
  logic [31:0] q6_q, v1p5_q, p2v1_q, v2a_q, p3q_q, v1p5b_q, p2v1b_q;
  logic [31:0] v2b_q, v1c_q, v2_q, m_q, div10_q, pn_q, div11_q, p11_q;
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, q0;

  assign t1 = {16'd0, cfg_i.t1};
  assign t2 = sx16(cfg_i.t2);
  assign t3 = sx16(cfg_i.t3);
  assign p1 = {16'd0, cfg_i.p1};
  assign p2 = sx16(cfg_i.plo[15:0]);
  assign p3 = sx16(cfg_i.plo[31:16]);
  assign p4 = sx16(cfg_i.plo[47:32]);
  assign p5 = sx16(cfg_i.plo[63:48]);
  assign p6 = sx16(cfg_i.phi[15:0]);
  assign q0 = asr(v15_q, 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0_q     <= {15'd0, temp_adc_i[19:3]} - {15'd0, cfg_i.t1, 1'b0};
      d_q      <= {16'd0, temp_adc_i[19:4]} - t1;
      rp_q[1]  <= press_adc_i;
      for (int i = 2; i <= 9; i++) begin
        rp_q[i] <= rp_q[i-1];
      end
      a1_q     <= a0_q * t2;
      dd_q     <= d_q * d_q;
      a3_q     <= asr(a1_q, 11);
      b3_q     <= asr(dd_q, 12) * t3;
      fine_q   <= a3_q + asr(b3_q, 14);
      t5_q     <= 32'(fine_q * 32'd5 + 32'd128);
      v15_q    <= asr(fine_q, 1) - 32'd64000;
      temp_q[6] <= asr(t5_q, 8);
      for (int i = 7; i <= 11; i++) begin
        temp_q[i] <= temp_q[i-1];
      end
      q6_q     <= q0 * q0;
      v1p5_q   <= v15_q * p5;
      p2v1_q   <= p2 * v15_q;
      v2a_q    <= asr(q6_q, 11) * p6;
      p3q_q    <= p3 * asr(q6_q, 13);
      v1p5b_q  <= v1p5_q;
      p2v1b_q  <= p2v1_q;
      v2b_q    <= v2a_q + {v1p5b_q[30:0], 1'b0};
      v1c_q    <= asr(asr(p3q_q, 3) + asr(p2v1b_q, 1), 18);
      v2_q     <= asr(v2b_q, 2) + {p4[15:0], 16'd0};
      m_q      <= (32'd32768 + v1c_q) * p1;
      div10_q  <= asr(m_q, 15);
      pn_q     <= (32'd1048576 - {12'd0, rp_q[9]}) - asr(v2_q, 12);
      div11_q  <= div10_q;
      p11_q    <= pn_q * 32'd3125;
    end
  end

  assign valid_o        = v_q[Stages-1];
  assign data_o.temp    = temp_q[11];
  assign data_o.divisor = div11_q;
  assign data_o.num     = p11_q;
endmodule

/* hw/rtl/btpc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module btpc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  btpc_pkg::front_t     data_i,
  output logic                 valid_o,
  output btpc_pkg::quo_t       data_o
);
  import btpc_pkg::*;

  logic [DivSteps-1:0] v_q;
  logic [31:0] rem_q [DivSteps];
  logic [31:0] num_q [DivSteps];
  logic [31:0] quo_q [DivSteps];
  logic [31:0] dvs_q [DivSteps];
  side_t       side_q [DivSteps];

  logic [31:0] rem_in [DivSteps];
  logic [31:0] num_in [DivSteps];
  logic [31:0] quo_in [DivSteps];
  logic [31:0] dvs_in [DivSteps];
  side_t       side_in [DivSteps];
  side_t       side0;

  // small dividends are doubled before dividing, large ones after
  assign side0.temp = data_i.temp;
  assign side0.big  = data_i.num[31];
  assign side0.zero = (data_i.divisor == 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivSteps-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [32:0] r;
    logic        ge;
    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign quo_in[k]  = '0;
      assign num_in[k]  = data_i.num[31] ? data_i.num : {data_i.num[30:0], 1'b0};
      assign dvs_in[k]  = data_i.divisor;
      assign side_in[k] = side0;
    end else begin : g_rest
      assign rem_in[k]  = rem_q[k-1];
      assign quo_in[k]  = quo_q[k-1];
      assign num_in[k]  = num_q[k-1];
      assign dvs_in[k]  = dvs_q[k-1];
      assign side_in[k] = side_q[k-1];
    end
    assign r  = {rem_in[k], num_in[k][31]};
    assign ge = (r >= {1'b0, dvs_in[k]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 32'(r - {1'b0, dvs_in[k]}) : r[31:0];
        quo_q[k]  <= {quo_in[k][30:0], ge};
        num_q[k]  <= {num_in[k][30:0], 1'b0};
        dvs_q[k]  <= dvs_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o     = v_q[DivSteps-1];
  assign data_o.quo  = quo_q[DivSteps-1];
  assign data_o.side = side_q[DivSteps-1];
endmodule

/* hw/rtl/btpc_post.sv */
// Nonlinear pressure correction after the division; last stage is the output register.
module btpc_post (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  btpc_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  input  btpc_pkg::quo_t       data_i,
  output logic                 valid_o,
  output logic [31:0]          temp_o,
  output logic [31:0]          press_o,
  output logic                 zero_o
);
  import btpc_pkg::*;

  logic [3:0]  v_q;
  logic [31:0] p_q [1:3];
  side_t       side_q [1:3];
  logic [31:0] sq_q, p8m_q, v1m_q, v2_q, s_q;
  logic [31:0] temp_q, press_q;
  logic        zero_q;
  logic [31:0] pin, ps, p7, p8, p9;

  assign p7  = sx16(cfg_i.phi[31:16]);
  assign p8  = sx16(cfg_i.phi[47:32]);
  assign p9  = sx16(cfg_i.phi[63:48]);
  assign pin = data_i.side.big ? {data_i.quo[30:0], 1'b0} : data_i.quo;
  assign ps  = {3'd0, pin[31:3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[1]    <= pin;
      side_q[1] <= data_i.side;
      sq_q      <= ps * ps;
      p8m_q     <= {2'd0, pin[31:2]} * p8;
      p_q[2]    <= p_q[1];
      side_q[2] <= side_q[1];
      v1m_q     <= p9 * {13'd0, sq_q[31:13]};
      v2_q      <= asr(p8m_q, 13);
      p_q[3]    <= p_q[2];
      side_q[3] <= side_q[2];
      s_q       <= asr(v1m_q, 12) + v2_q + p7;
      temp_q    <= side_q[3].temp;
      zero_q    <= side_q[3].zero;
      press_q   <= side_q[3].zero ? 32'd0 : p_q[3] + asr(s_q, 4);
    end
  end

  assign valid_o = v_q[3];
  assign temp_o  = temp_q;
  assign press_o = press_q;
  assign zero_o  = zero_q;
endmodule
